### hdl/cpcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_pkg
// Shared types and constants of the cluster pair cost reducer.
// ----------------------------------------------------------------------------
package cpcr_pkg;

  localparam int COST_W    = 32;
  localparam int POS_W     = 6;
  localparam int SUM_W     = COST_W + 12;
  localparam int CNT_W     = 13;
  localparam int MODE_W    = 2;
  localparam int SB_DEPTH  = 64;
  localparam int DIV_CNT_W = 6;
  localparam int DATA_W    = 48;
  localparam int REG_W     = 32;
  localparam int ADDR_W    = 3;

  localparam logic [COST_W-1:0] COST_MAXV = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic [COST_W-1:0] COST_MINV = {1'b1, {(COST_W-1){1'b0}}};

  // aggregate mode codes
  localparam logic [MODE_W-1:0] AGG_MIN = 2'd0;
  localparam logic [MODE_W-1:0] AGG_MAX = 2'd1;
  localparam logic [MODE_W-1:0] AGG_AVG = 2'd2;

  // register index codes (paddr[2])
  localparam logic REG_AGG_MODE = 1'b0;
  localparam logic REG_IDX_MODE = 1'b1;

  // result kind codes
  localparam logic KIND_ROW  = 1'b0;
  localparam logic KIND_PAIR = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [COST_W-1:0] value;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              taken;
    logic              last;
    logic              is_avg;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
  } cpcr_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cpcr_qstat_t;

  typedef enum logic [1:0] {
    F_ACCEPT,
    F_LOOKUP,
    F_SUMMARY
  } cpcr_front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } cpcr_back_state_e;

endpackage
`default_nettype wire

### hdl/cpcr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_front
// Accepts costs, keeps the pair and row accumulators and the per-column
// entrance scoreboard, and queues row records and pair summaries.
// ----------------------------------------------------------------------------
module cpcr_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [cpcr_pkg::MODE_W-1:0]   agg_mode_i,
  input  wire logic                          idx_mode_i,
  input  wire logic                          s_valid_i,
  output logic                               s_ready_o,
  input  wire logic [cpcr_pkg::COST_W-1:0]   cost_i,
  input  wire logic [cpcr_pkg::POS_W-1:0]    row_i,
  input  wire logic [cpcr_pkg::POS_W-1:0]    col_i,
  input  wire logic                          row_last_i,
  input  wire logic                          pair_last_i,
  input  wire cpcr_pkg::cpcr_qstat_t         qstat_i,
  output logic                               push_o,
  output cpcr_pkg::cpcr_job_t                push_job_o
);

  cpcr_pkg::cpcr_front_state_e state_q, state_d;

  logic [cpcr_pkg::COST_W-1:0] min_q, max_q, rmin_q, rec_cost_q, sb_rdata_q;
  logic [cpcr_pkg::SUM_W-1:0]  sum_q;
  logic [cpcr_pkg::CNT_W-1:0]  cnt_q;
  logic [cpcr_pkg::POS_W-1:0]  brow_q, bcol_q, rcol_q, rec_col_q, rec_row_q;
  logic                        pair_open_q, row_open_q, pend_sum_q;
  logic [cpcr_pkg::SB_DEPTH-1:0] sb_valid_q;
  cpcr_pkg::cpcr_job_t         sum_hold_q;

  logic [cpcr_pkg::COST_W-1:0] sb_cost_mem [cpcr_pkg::SB_DEPTH];

  logic [cpcr_pkg::COST_W-1:0] nxt_min, nxt_max, nxt_rmin;
  logic [cpcr_pkg::SUM_W-1:0]  nxt_sum;
  logic [cpcr_pkg::CNT_W-1:0]  nxt_cnt;
  logic [cpcr_pkg::POS_W-1:0]  nxt_brow, nxt_bcol, nxt_rcol;
  logic                        accept, closing, taken, lookup_fire;
  cpcr_pkg::cpcr_job_t         sum_job, rec_job;

  assign accept  = (state_q == cpcr_pkg::F_ACCEPT) && s_valid_i && !qstat_i.full;
  assign closing = row_last_i || pair_last_i;

  // running values including the incoming cost
  always_comb begin
    nxt_min  = min_q;
    nxt_brow = brow_q;
    nxt_bcol = bcol_q;
    if (!pair_open_q || ($signed(cost_i) < $signed(min_q))) begin
      nxt_min  = cost_i;
      nxt_brow = row_i;
      nxt_bcol = col_i;
    end
    nxt_max = max_q;
    if (!pair_open_q || ($signed(cost_i) > $signed(max_q))) begin
      nxt_max = cost_i;
    end
    nxt_sum = sum_q + {{(cpcr_pkg::SUM_W-cpcr_pkg::COST_W){cost_i[cpcr_pkg::COST_W-1]}},
                       cost_i};
    nxt_cnt = cnt_q + 1'b1;
    nxt_rmin = rmin_q;
    nxt_rcol = rcol_q;
    if (!row_open_q || ($signed(cost_i) < $signed(rmin_q))) begin
      nxt_rmin = cost_i;
      nxt_rcol = col_i;
    end
  end

  always_comb begin
    sum_job        = '0;
    sum_job.kind   = cpcr_pkg::KIND_PAIR;
    sum_job.row    = nxt_brow;
    sum_job.col    = nxt_bcol;
    sum_job.last   = 1'b1;
    sum_job.sum    = nxt_sum;
    sum_job.cnt    = nxt_cnt;
    case (agg_mode_i)
      cpcr_pkg::AGG_MAX: sum_job.value = nxt_max;
      cpcr_pkg::AGG_AVG: begin
        // a wrapped count of zero averages to zero
        sum_job.value  = '0;
        sum_job.is_avg = (nxt_cnt != '0);
      end
      default:           sum_job.value = nxt_min;
    endcase
  end

  assign taken = !sb_valid_q[rec_col_q] || ($signed(rec_cost_q) > $signed(sb_rdata_q));

  always_comb begin
    rec_job       = '0;
    rec_job.kind  = cpcr_pkg::KIND_ROW;
    rec_job.value = rec_cost_q;
    rec_job.row   = rec_row_q;
    rec_job.col   = rec_col_q;
    rec_job.taken = taken;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpcr_pkg::F_ACCEPT: begin
        if (accept && idx_mode_i && closing) state_d = cpcr_pkg::F_LOOKUP;
      end
      cpcr_pkg::F_LOOKUP: begin
        if (!qstat_i.full) state_d = pend_sum_q ? cpcr_pkg::F_SUMMARY : cpcr_pkg::F_ACCEPT;
      end
      cpcr_pkg::F_SUMMARY: begin
        if (!qstat_i.full) state_d = cpcr_pkg::F_ACCEPT;
      end
      default: state_d = cpcr_pkg::F_ACCEPT;
    endcase
  end

  // outputs
  always_comb begin
    s_ready_o   = 1'b0;
    push_o      = 1'b0;
    push_job_o  = sum_job;
    lookup_fire = 1'b0;
    case (state_q)
      cpcr_pkg::F_ACCEPT: begin
        s_ready_o = !qstat_i.full;
        push_o    = accept && pair_last_i && !idx_mode_i;
      end
      cpcr_pkg::F_LOOKUP: begin
        push_o      = !qstat_i.full;
        push_job_o  = rec_job;
        lookup_fire = !qstat_i.full;
      end
      cpcr_pkg::F_SUMMARY: begin
        push_o     = !qstat_i.full;
        push_job_o = sum_hold_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpcr_pkg::F_ACCEPT;
      min_q       <= cpcr_pkg::COST_MAXV;
      max_q       <= cpcr_pkg::COST_MINV;
      sum_q       <= '0;
      cnt_q       <= '0;
      brow_q      <= '0;
      bcol_q      <= '0;
      rmin_q      <= cpcr_pkg::COST_MAXV;
      rcol_q      <= '0;
      pair_open_q <= 1'b0;
      row_open_q  <= 1'b0;
      pend_sum_q  <= 1'b0;
      sb_valid_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pend_sum_q <= pair_last_i;
        if (pair_last_i) begin
          min_q       <= cpcr_pkg::COST_MAXV;
          max_q       <= cpcr_pkg::COST_MINV;
          sum_q       <= '0;
          cnt_q       <= '0;
          brow_q      <= '0;
          bcol_q      <= '0;
          pair_open_q <= 1'b0;
          // the scoreboard empties at every pair end, whatever the index mode
          if (!idx_mode_i) begin
            sb_valid_q <= '0;
          end
        end else begin
          min_q       <= nxt_min;
          max_q       <= nxt_max;
          sum_q       <= nxt_sum;
          cnt_q       <= nxt_cnt;
          brow_q      <= nxt_brow;
          bcol_q      <= nxt_bcol;
          pair_open_q <= 1'b1;
        end
        if (closing) begin
          rmin_q     <= cpcr_pkg::COST_MAXV;
          rcol_q     <= '0;
          row_open_q <= 1'b0;
        end else begin
          rmin_q     <= nxt_rmin;
          rcol_q     <= nxt_rcol;
          row_open_q <= 1'b1;
        end
      end
      if (lookup_fire) begin
        if (pend_sum_q) begin
          sb_valid_q <= '0;
        end else if (taken) begin
          sb_valid_q[rec_col_q] <= 1'b1;
        end
      end
    end
  end

  // record and summary holding registers
  always_ff @(posedge clk_i) begin
    if (accept && closing) begin
      rec_cost_q <= nxt_rmin;
      rec_col_q  <= nxt_rcol;
      rec_row_q  <= row_i;
      sum_hold_q <= sum_job;
    end
  end

  // scoreboard cost memory, read on each accepted cost for use at row close, written in the lookup state when taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sb_rdata_q <= sb_cost_mem[nxt_rcol];
    end
    if (lookup_fire && taken) begin
      sb_cost_mem[rec_col_q] <= rec_cost_q;
    end
  end

endmodule
`default_nettype wire

### hdl/cpcr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_queue
// Two-entry queue of result jobs between the front and the back.
// ----------------------------------------------------------------------------
module cpcr_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire cpcr_pkg::cpcr_job_t   push_job_i,
  input  wire logic                  pop_i,
  output cpcr_pkg::cpcr_job_t        head_o,
  output cpcr_pkg::cpcr_qstat_t      qstat_o
);

  cpcr_pkg::cpcr_job_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign qstat_o.full  = (count_q == 2'd2);
  assign qstat_o.empty = (count_q == 2'd0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

### hdl/cpcr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_back
// Drains the job queue into the output register; average summaries go
// through a bit-serial signed divider first.
// ----------------------------------------------------------------------------
module cpcr_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cpcr_pkg::cpcr_job_t   head_i,
  input  wire cpcr_pkg::cpcr_qstat_t qstat_i,
  output logic                       pop_o,
  output logic                       m_valid_o,
  input  wire logic                  m_ready_i,
  output cpcr_pkg::cpcr_job_t        m_job_o
);

  localparam logic [cpcr_pkg::DIV_CNT_W-1:0] LastStep =
    cpcr_pkg::DIV_CNT_W'(cpcr_pkg::SUM_W - 1);
  localparam logic [cpcr_pkg::SUM_W-1:0] PosLimit =
    {{(cpcr_pkg::SUM_W-cpcr_pkg::COST_W+1){1'b0}}, {(cpcr_pkg::COST_W-1){1'b1}}};

  cpcr_pkg::cpcr_back_state_e state_q, state_d;

  logic                            out_valid_q;
  cpcr_pkg::cpcr_job_t             out_job_q, div_job_q, load_job;
  logic [cpcr_pkg::SUM_W-1:0]      quo_q, quo_d, mag;
  logic [cpcr_pkg::CNT_W-1:0]      rem_q, rem_d, div_q;
  logic [cpcr_pkg::CNT_W:0]        rem_sh;
  logic [cpcr_pkg::DIV_CNT_W-1:0]  step_q;
  logic                            neg_q, ge, out_free, load_out, start_div;
  logic [cpcr_pkg::COST_W-1:0]     avg_value;

  assign out_free  = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;
  assign m_job_o   = out_job_q;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[cpcr_pkg::SUM_W-1]};
    ge     = (rem_sh >= {1'b0, div_q});
    rem_d  = ge ? cpcr_pkg::CNT_W'(rem_sh - {1'b0, div_q}) : rem_sh[cpcr_pkg::CNT_W-1:0];
    quo_d  = {quo_q[cpcr_pkg::SUM_W-2:0], ge};
    mag    = head_i.sum[cpcr_pkg::SUM_W-1] ? (~head_i.sum + 1'b1) : head_i.sum;
  end

  // truncated quotient, saturated to the cost range
  always_comb begin
    if (neg_q) begin
      avg_value = (quo_q > (PosLimit + 1'b1)) ? cpcr_pkg::COST_MINV
                                              : (~quo_q[cpcr_pkg::COST_W-1:0] + 1'b1);
    end else begin
      avg_value = (quo_q > PosLimit) ? cpcr_pkg::COST_MAXV : quo_q[cpcr_pkg::COST_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpcr_pkg::B_IDLE: begin
        if (!qstat_i.empty && head_i.is_avg) state_d = cpcr_pkg::B_DIV;
      end
      cpcr_pkg::B_DIV: begin
        if (step_q == LastStep) state_d = cpcr_pkg::B_DONE;
      end
      cpcr_pkg::B_DONE: begin
        if (out_free) state_d = cpcr_pkg::B_IDLE;
      end
      default: state_d = cpcr_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o     = 1'b0;
    load_out  = 1'b0;
    start_div = 1'b0;
    load_job  = head_i;
    case (state_q)
      cpcr_pkg::B_IDLE: begin
        start_div = !qstat_i.empty && head_i.is_avg;
        load_out  = !qstat_i.empty && !head_i.is_avg && out_free;
        pop_o     = start_div || load_out;
      end
      cpcr_pkg::B_DONE: begin
        load_out       = out_free;
        load_job       = div_job_q;
        load_job.value = avg_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpcr_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (start_div) begin
        step_q <= '0;
      end else if (state_q == cpcr_pkg::B_DIV) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_job_q <= load_job;
    end
    if (start_div) begin
      div_job_q <= head_i;
      quo_q     <= mag;
      rem_q     <= '0;
      div_q     <= head_i.cnt;
      neg_q     <= head_i.sum[cpcr_pkg::SUM_W-1];
    end else if (state_q == cpcr_pkg::B_DIV) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

endmodule
`default_nettype wire

### hdl/cluster_pair_cost_reducer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_pair_cost_reducer
// Reduces the costs between two clusters to a min, max or average summary,
// with optional per-row best-column records and an entrance scoreboard.
// ----------------------------------------------------------------------------
//  channel   dir  signals                  carries
//  s_axis    in   tvalid/tready/tdata/...  one cost, row, column, row/pair end
//  m_axis    out  tvalid/tready/tdata/...  row record or pair summary
//  apb       in   psel/penable/pwrite/...  aggregate_mode @0, index_mode @4
//
//  A cost is taken each cycle unless the queue is full or a lookup or summary
//  is pending. Per-row mode holds the input on a closing item for the scoreboard
//  lookup and record, and at pair end for the summary. An average summary passes
//  the back-end divider, then a load; the two-entry queue lets the input run on.
//  Reset clears modes, accumulators and all scoreboard valid bits at once.
//  An output stall holds the output register; the input stalls on a full queue.
// ----------------------------------------------------------------------------
module cluster_pair_cost_reducer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // cost[31:0], row_pos[37:32], col_pos[43:38], zero pad
  input  wire logic [cpcr_pkg::DATA_W-1:0]   s_axis_tdata,
  // row_last
  input  wire logic                          s_axis_tuser,
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // value[31:0], row_position[37:32], col_position[43:38], entrance_taken[44], zero pad
  output logic [cpcr_pkg::DATA_W-1:0]        m_axis_tdata,
  // kind
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cpcr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [cpcr_pkg::REG_W-1:0]    pwdata,
  output logic [cpcr_pkg::REG_W-1:0]         prdata,
  output logic                               pready
);

  logic [cpcr_pkg::MODE_W-1:0] agg_mode_q;
  logic                        idx_mode_q;
  logic                        push, pop;
  cpcr_pkg::cpcr_job_t         push_job, head_job, out_job;
  cpcr_pkg::cpcr_qstat_t       qstat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agg_mode_q <= cpcr_pkg::AGG_MIN;
      idx_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        cpcr_pkg::REG_AGG_MODE: agg_mode_q <= pwdata[cpcr_pkg::MODE_W-1:0];
        cpcr_pkg::REG_IDX_MODE: idx_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cpcr_pkg::REG_AGG_MODE:
        prdata = {{(cpcr_pkg::REG_W-cpcr_pkg::MODE_W){1'b0}}, agg_mode_q};
      cpcr_pkg::REG_IDX_MODE:
        prdata = {{(cpcr_pkg::REG_W-1){1'b0}}, idx_mode_q};
      default: prdata = '0;
    endcase
  end

  cpcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .agg_mode_i  (agg_mode_q),
    .idx_mode_i  (idx_mode_q),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .cost_i      (s_axis_tdata[31:0]),
    .row_i       (s_axis_tdata[37:32]),
    .col_i       (s_axis_tdata[43:38]),
    .row_last_i  (s_axis_tuser),
    .pair_last_i (s_axis_tlast),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  cpcr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .qstat_o    (qstat)
  );

  cpcr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head_job),
    .qstat_i   (qstat),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_job_o   (out_job)
  );

  assign m_axis_tdata = {3'b000, out_job.taken, out_job.col, out_job.row, out_job.value};
  assign m_axis_tuser = out_job.kind;
  assign m_axis_tlast = out_job.last;

endmodule
`default_nettype wire
